// ===== hdl/imhq_pkg.sv =====
// Package with request and status codes for the indexed min-heap queue.
`default_nettype none
package imhq_pkg;
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_UPDATE = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_GET    = 3'd4;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_POS  = 3'd2;
  localparam logic [2:0] ST_NOID = 3'd3;
  localparam logic [2:0] ST_DUP  = 3'd4;

  localparam int IDENT_W = 8;
  localparam int PRIOF_W = 16;
  localparam int POSF_W  = 6;
  localparam int CNTF_W  = 7;
endpackage
`default_nettype wire

// ===== hdl/imhq_cmp.sv =====
// Shared priority comparator used by every sift step.
`default_nettype none
module imhq_cmp #(
  parameter int PRIO_WIDTH = 16
) (
  input  wire logic [PRIO_WIDTH-1:0] a,
  input  wire logic [PRIO_WIDTH-1:0] b,
  output logic                       a_less,
  output logic                       a_less_eq
);
  assign a_less    = a < b;
  assign a_less_eq = a <= b;
endmodule
`default_nettype wire

// ===== hdl/indexed_min_heap_queue_core.sv =====
// Top level of the indexed min-heap queue: sequencer, heap memories and index table.
//
// Channel  Dir  Fields (tdata from bit 0 up)
// s_axis   in   tdata: task_ident[7:0], prio_value[23:8], heap_pos[29:24]; tuser: req_type
// m_axis   out  tdata: status[2:0], read_ident[10:3], found_pos[16:11], top_ident[24:17],
//                      top_prio[40:25], entry_count[47:41], is_empty[48]
//
// One beat is handled at a time; s_axis_tready is high only in the idle state.
// A find, get or rejected request passes from the look and decode states straight
// to the top-entry read and the output register. A push, remove or update
// walks the heap one level per step through a single memory read port and one
// shared comparator: sift up reads the parent, compares and swaps for each level,
// and sift down reads the left child, reads the right child, compares and swaps.
// Reset clears the presence bits and the count at once; no clearing pass is needed.
// A result waits in the output register; the next beat is taken once it is accepted.
`default_nettype none
module indexed_min_heap_queue_core #(
  parameter int CAPACITY   = 64,
  parameter int ID_SPACE   = 256,
  parameter int PRIO_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // task_ident, prio_value, heap_pos from bit 0 up
  input  wire logic [31:0] s_axis_tdata,
  // req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status, read_ident, found_pos, top_ident, top_prio, entry_count, is_empty
  output logic [55:0]      m_axis_tdata
);
  import imhq_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (ID_SPACE > 2) ? $clog2(ID_SPACE) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_DEC = 4'd2,
    S_UPRD = 4'd3, S_UPCMP = 4'd4, S_DNL = 4'd5, S_DNR = 4'd6, S_DNCMP = 4'd7,
    S_SWAP = 4'd8, S_TOP = 4'd9, S_TOPW = 4'd10, S_OUT = 4'd11, S_MOVE = 4'd12,
    S_MOVEW = 4'd13;

  logic [3:0] state;
  logic [CW-1:0] count;
  logic [ID_SPACE-1:0] present;
  logic [IDENT_W-1:0] id_mem [CAPACITY];
  logic [PRIO_WIDTH-1:0] pr_mem [CAPACITY];
  logic [PW-1:0] pos_mem [ID_SPACE];

  // latched request
  logic [2:0] req;
  logic [IDENT_W-1:0] rid;
  logic [PRIO_WIDTH-1:0] rprio;
  logic [POSF_W-1:0] rpos;

  // current slot and its contents, candidate slot contents
  logic [PW-1:0] cur, oth, best;
  logic [IDENT_W-1:0] cid, bid;
  logic [PRIO_WIDTH-1:0] cpr, bpr;
  logic bvalid;
  logic up_phase;

  logic [2:0] o_status;
  logic [IDENT_W-1:0] o_rd, o_tid;
  logic [POSF_W-1:0] o_fp;
  logic [PRIOF_W-1:0] o_tpr;

  // one read port per memory; heap slot address chosen by the sequencer, index table read at the latched ident
  logic [PW-1:0] raddr;
  logic [IDENT_W-1:0] rd_id;
  logic [PRIO_WIDTH-1:0] rd_pr;
  logic [PW-1:0] rd_pos;

  logic we;
  logic [PW-1:0] waddr;
  logic [IDENT_W-1:0] wid;
  logic [PRIO_WIDTH-1:0] wpr;

  logic [PRIO_WIDTH-1:0] cmp_a, cmp_b;
  logic lt, le;

  imhq_cmp #(.PRIO_WIDTH(PRIO_WIDTH)) u_cmp (
    .a(cmp_a), .b(cmp_b), .a_less(lt), .a_less_eq(le)
  );

  logic id_ok;
  logic [IW-1:0] idx;
  logic [PW-1:0] parent;
  logic [PW+1:0] lch, rch;
  logic [PW+1:0] cnt_ext;

  assign idx     = IW'(rid);
  assign id_ok   = 32'(rid) < ID_SPACE;
  assign parent  = (cur - PW'(1)) >> 1;
  assign lch     = {1'b0, cur, 1'b1};
  assign rch     = lch + (PW+2)'(1);
  assign cnt_ext = (PW+2)'(count);

  always_ff @(posedge clk) begin
    rd_id <= id_mem[raddr];
    rd_pr <= pr_mem[raddr];
    rd_pos <= pos_mem[idx];
    if (we) begin
      id_mem[waddr] <= wid;
      pr_mem[waddr] <= wpr;
      pos_mem[IW'(wid)] <= waddr;
    end
  end

  always_comb begin
    raddr = cur;
    case (state)
      S_IDLE:  raddr = PW'(s_axis_tdata[29:24]);
      S_LOOK:  raddr = PW'(rpos);
      S_DEC:   raddr = PW'(count - CW'(1));
      S_MOVE:  raddr = PW'(count);
      S_UPRD:  raddr = parent;
      S_DNL:   raddr = lch[PW-1:0];
      S_DNR:   raddr = rch[PW-1:0];
      S_TOP:   raddr = '0;
      default: raddr = cur;
    endcase
    cmp_a = bpr;
    cmp_b = cpr;
    if (state == S_UPCMP) begin
      cmp_a = rd_pr;
      cmp_b = cpr;
    end else if (state == S_DNR || state == S_DNCMP) begin
      cmp_a = rd_pr;
      cmp_b = bpr;
    end
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      present <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req <= s_axis_tuser;
            rid <= s_axis_tdata[7:0];
            rprio <= PRIO_WIDTH'(s_axis_tdata[8 +: PRIOF_W]);
            rpos <= s_axis_tdata[29:24];
            o_rd <= '0;
            o_fp <= '0;
            o_status <= ST_OK;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          // read data for heap_pos and pos_of_ident are ready next cycle
          state <= S_DEC;
        end
        S_DEC: begin
          state <= S_TOP;
          case (req)
            REQ_PUSH: begin
              if (!id_ok) o_status <= ST_NOID;
              else if (present[idx]) o_status <= ST_DUP;
              else if (32'(count) >= CAPACITY) o_status <= ST_FULL;
              else begin
                present[idx] <= 1'b1;
                cur <= PW'(count);
                cid <= rid;
                cpr <= rprio;
                we <= 1'b1;
                waddr <= PW'(count);
                wid <= rid;
                wpr <= rprio;
                count <= count + CW'(1);
                up_phase <= 1'b0;
                state <= S_UPRD;
              end
            end
            REQ_REMOVE: begin
              if (32'(rpos) >= 32'(count)) o_status <= ST_POS;
              else begin
                present[IW'(rd_id)] <= 1'b0;
                cur <= PW'(rpos);
                state <= (32'(rpos) == 32'(count) - 1) ? S_TOP : S_MOVE;
                count <= count - CW'(1);
              end
            end
            REQ_UPDATE: begin
              if (!id_ok || !present[idx]) o_status <= ST_NOID;
              else begin
                cur <= rd_pos;
                cid <= rid;
                cpr <= rprio;
                we <= 1'b1;
                waddr <= rd_pos;
                wid <= rid;
                wpr <= rprio;
                up_phase <= 1'b1;
                state <= S_UPRD;
              end
            end
            REQ_FIND: begin
              if (!id_ok || !present[idx]) o_status <= ST_NOID;
              else o_fp <= POSF_W'(rd_pos);
            end
            REQ_GET: begin
              if (32'(rpos) >= 32'(count)) o_status <= ST_POS;
              else o_rd <= rd_id;
            end
            default: ;
          endcase
        end
        S_MOVE: state <= S_MOVEW; // read of the last slot is issued in this cycle
        S_MOVEW: begin
          cid <= rd_id;
          cpr <= rd_pr;
          we <= 1'b1;
          waddr <= cur;
          wid <= rd_id;
          wpr <= rd_pr;
          up_phase <= 1'b1;
          state <= S_UPRD;
        end
        S_UPRD: begin
          if (cur == '0) state <= up_phase ? S_DNL : S_TOP;
          else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (le) state <= up_phase ? S_DNL : S_TOP;
          else begin
            // parent moves down into cur, current entry moves up
            we <= 1'b1;
            waddr <= cur;
            wid <= rd_id;
            wpr <= rd_pr;
            oth <= parent;
            up_phase <= 1'b0;
            state <= S_SWAP;
          end
        end
        S_DNL: begin
          best <= cur;
          bid <= cid;
          bpr <= cpr;
          bvalid <= 1'b0;
          state <= S_DNR;
        end
        S_DNR: begin
          if (lch < cnt_ext && lt) begin
            best <= lch[PW-1:0];
            bid <= rd_id;
            bpr <= rd_pr;
            bvalid <= 1'b1;
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (rch < cnt_ext && lt) begin
            oth <= rch[PW-1:0];
            we <= 1'b1;
            waddr <= cur;
            wid <= rd_id;
            wpr <= rd_pr;
            state <= S_SWAP;
          end else if (bvalid) begin
            oth <= best;
            we <= 1'b1;
            waddr <= cur;
            wid <= bid;
            wpr <= bpr;
            state <= S_SWAP;
          end else state <= S_TOP;
        end
        S_SWAP: begin
          we <= 1'b1;
          waddr <= oth;
          wid <= cid;
          wpr <= cpr;
          cur <= oth;
          state <= up_phase ? S_DNL : S_UPRD;
        end
        S_TOP: state <= S_TOPW;
        S_TOPW: begin
          o_tid <= (count != '0) ? rd_id : '0;
          o_tpr <= (count != '0) ? PRIOF_W'(rd_pr) : '0;
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata = {7'd0, (count == '0), CNTF_W'(count), o_tpr, o_tid, o_fp,
                         o_rd, o_status};
endmodule
`default_nettype wire
